@@ src/pulse_channel_duty_sweep_defines.svh @@
// Assertion macros shared by the pulse channel RTL.
// Relies on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef PULSE_CHANNEL_DUTY_SWEEP_DEFINES_SVH
`define PULSE_CHANNEL_DUTY_SWEEP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PCDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pulse channel assertion failed");

// Next-cycle implication.
`define PCDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pulse channel assertion failed");

`else

`define PCDS_ASSERT_IMP(lbl, ante, cons)
`define PCDS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ src/pcds_pkg.sv @@
// Package for the pulse channel: action codes, beat structs, duty patterns.
// No dependencies; used by pcds_core and pulse_channel_duty_sweep.
package pcds_pkg;

  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned TIMER_W  = 13;
  localparam int unsigned LEVEL_W  = 4;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD = 11'h008;

  // Configuration register byte addresses.
  localparam logic [2:0] ADDR_NEGATE_MODE = 3'd0;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SWEEP_CLK = 3'd1,
    ACT_DUTY_WR   = 3'd2,
    ACT_SWEEP_WR  = 3'd3,
    ACT_PERIOD_LO = 3'd4,
    ACT_PERIOD_HI = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         data;
    logic [LEVEL_W-1:0] envelope_level;
    logic               length_active;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  sample;
    logic                sample_update;
    logic [PERIOD_W-1:0] period_now;
  } result_t;

  // The four 8-step duty patterns, step 0 first.
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'b0000_0010;
      2'd1:    pat = 8'b0000_0110;
      2'd2:    pat = 8'b0001_1110;
      2'd3:    pat = 8'b1111_1001;
      default: pat = 8'b0000_0000;
    endcase
    return pat[step];
  endfunction

endpackage

@@ src/pcds_core.sv @@
// Channel state and the combinational update for one beat: timer, duty sequencer, sweep.
// Depends on pcds_pkg and pulse_channel_duty_sweep_defines.svh.
`include "pulse_channel_duty_sweep_defines.svh"

module pcds_core
  import pcds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  logic    negate_mode,
  output result_t result
);

  logic [1:0]          duty_select_r, duty_select_nxt;
  logic [2:0]          duty_step_r, duty_step_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [TIMER_W-1:0]  timer_count_r, timer_count_nxt;
  logic                sweep_enabled_r, sweep_enabled_nxt;
  logic [2:0]          sweep_div_period_r, sweep_div_period_nxt;
  logic                sweep_negate_r, sweep_negate_nxt;
  logic [2:0]          sweep_shift_r, sweep_shift_nxt;
  logic [7:0]          sweep_divider_r, sweep_divider_nxt;
  logic                reload_pending_r, reload_pending_nxt;
  logic [LEVEL_W-1:0]  held_sample_r, held_sample_nxt;

  logic [PERIOD_W-1:0] delta;
  logic [PERIOD_W:0]   target;
  logic                period_ok;
  logic [PERIOD_W-1:0] swept_period;
  logic [7:0]          div_dec;
  logic [7:0]          div_reload;
  logic                updated;

  // The sweep target is checked for a carry out of the period only when
  // negating is off; a negated sweep can never overflow.
  assign delta      = period_r >> sweep_shift_r;
  assign target     = {1'b0, period_r} + {1'b0, delta};
  assign period_ok  = (period_r >= MIN_PERIOD) && (sweep_negate_r || !target[PERIOD_W]);
  assign div_dec    = sweep_divider_r - 8'd1;
  assign div_reload = {5'd0, sweep_div_period_r} + 8'd1;

  always_comb begin
    if (sweep_negate_r) begin
      swept_period = period_r - delta - {{(PERIOD_W-1){1'b0}}, ~negate_mode};
    end else begin
      swept_period = target[PERIOD_W-1:0];
    end
  end

  always_comb begin
    duty_select_nxt      = duty_select_r;
    duty_step_nxt        = duty_step_r;
    period_nxt           = period_r;
    timer_count_nxt      = timer_count_r;
    sweep_enabled_nxt    = sweep_enabled_r;
    sweep_div_period_nxt = sweep_div_period_r;
    sweep_negate_nxt     = sweep_negate_r;
    sweep_shift_nxt      = sweep_shift_r;
    sweep_divider_nxt    = sweep_divider_r;
    reload_pending_nxt   = reload_pending_r;
    held_sample_nxt      = held_sample_r;
    updated              = 1'b0;
    case (action_t'(item.action))
      ACT_TICK: begin
        if (timer_count_r <= TIMER_W'(1)) begin
          timer_count_nxt = {({1'b0, period_r} + 12'd1), 1'b0};
          duty_step_nxt   = duty_step_r + 3'd1;
          if (item.length_active && period_ok &&
              duty_bit(duty_select_r, duty_step_nxt)) begin
            held_sample_nxt = item.envelope_level;
          end else begin
            held_sample_nxt = '0;
          end
          updated = 1'b1;
        end else begin
          timer_count_nxt = timer_count_r - TIMER_W'(1);
        end
      end
      ACT_SWEEP_CLK: begin
        sweep_divider_nxt = div_dec;
        if (div_dec == 8'd0) begin
          sweep_divider_nxt = div_reload;
          if (sweep_enabled_r && (sweep_shift_r != 3'd0) && period_ok) begin
            period_nxt = swept_period;
          end
        end
        if (reload_pending_r) begin
          reload_pending_nxt = 1'b0;
          sweep_divider_nxt  = div_reload;
        end
      end
      ACT_DUTY_WR: begin
        duty_select_nxt = item.data[7:6];
      end
      ACT_SWEEP_WR: begin
        sweep_enabled_nxt    = item.data[7];
        sweep_div_period_nxt = item.data[6:4];
        sweep_negate_nxt     = item.data[3];
        sweep_shift_nxt      = item.data[2:0];
        reload_pending_nxt   = 1'b1;
      end
      ACT_PERIOD_LO: begin
        period_nxt = {period_r[PERIOD_W-1:8], item.data};
      end
      ACT_PERIOD_HI: begin
        period_nxt    = {item.data[2:0], period_r[7:0]};
        duty_step_nxt = 3'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_select_r      <= '0;
      duty_step_r        <= '0;
      period_r           <= '0;
      timer_count_r      <= TIMER_W'(1);
      sweep_enabled_r    <= 1'b0;
      sweep_div_period_r <= '0;
      sweep_negate_r     <= 1'b0;
      sweep_shift_r      <= '0;
      sweep_divider_r    <= '0;
      reload_pending_r   <= 1'b0;
      held_sample_r      <= '0;
    end else if (step_en) begin
      duty_select_r      <= duty_select_nxt;
      duty_step_r        <= duty_step_nxt;
      period_r           <= period_nxt;
      timer_count_r      <= timer_count_nxt;
      sweep_enabled_r    <= sweep_enabled_nxt;
      sweep_div_period_r <= sweep_div_period_nxt;
      sweep_negate_r     <= sweep_negate_nxt;
      sweep_shift_r      <= sweep_shift_nxt;
      sweep_divider_r    <= sweep_divider_nxt;
      reload_pending_r   <= reload_pending_nxt;
      held_sample_r      <= held_sample_nxt;
    end
  end

  assign result.sample        = held_sample_nxt;
  assign result.sample_update = updated;
  assign result.period_now    = period_nxt;

  // A timer reload is always an even, nonzero count.
  `PCDS_ASSERT_NXT(a_timer_reload_even,
    step_en && (item.action == ACT_TICK) && (timer_count_r <= TIMER_W'(1)),
    (timer_count_r[0] == 1'b0) && (timer_count_r != '0))
  // A sweep register write always leaves a divider reload pending.
  `PCDS_ASSERT_NXT(a_sweep_wr_pending,
    step_en && (item.action == ACT_SWEEP_WR), reload_pending_r)
  // The held sample only changes on a timer expiry.
  `PCDS_ASSERT_NXT(a_sample_only_on_expiry,
    step_en && !updated, held_sample_r == $past(held_sample_r))

endmodule

@@ src/pulse_channel_duty_sweep.sv @@
// Top level of the pulse channel: input beat register, result register, APB register.
// Depends on pcds_pkg, pcds_core and pulse_channel_duty_sweep_defines.svh.
//
// Usage: each input beat carries an action (timer tick, sweep clock, or a
// write of the duty, sweep, period-low or period-high register byte), the data
// byte, the envelope level and the length-active flag. Every input beat gives
// exactly one result beat with the held sample, a flag telling whether the
// timer expired and the sample was recomputed, and the period after the beat.
// A beat accepted at a rising edge is captured in the input register and is
// processed once the result register is empty or being drained; its result is
// then captured in the result register, which drives out_valid. One beat is taken
// every cycle as long as the receiver keeps out_ready high; the combinational
// update of the channel state sets that rate. When the receiver stalls, the
// result register holds its beat, the input register fills, and in_ready
// drops until the result is taken; no beat is lost or repeated.
// Reset (rst_n low at a rising edge) empties both registers, clears the channel
// state with the timer count at one, and sets negate_mode to zero. negate_mode
// is the only configuration register, at byte address 0 of the APB port; it
// selects the subtract-plus-one form of the negated sweep when zero.
`include "pulse_channel_duty_sweep_defines.svh"

module pulse_channel_duty_sweep
  import pcds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_action,
  input  logic [7:0]          in_data,
  input  logic [LEVEL_W-1:0]  in_envelope_level,
  input  logic                in_length_active,
  // Result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  out_sample,
  output logic                out_sample_update,
  output logic [PERIOD_W-1:0] out_period_now,
  // Configuration port.
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_result_r;
  result_t core_result;
  logic    negate_mode_r;
  logic    advance;
  logic    step_en;
  logic    cfg_wr;
  logic    cfg_hit;

  // The pipeline moves whenever the result register is empty or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign step_en  = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{action: in_action, data: in_data,
                     envelope_level: in_envelope_level, length_active: in_length_active};
    end
  end

  pcds_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (s1_item_r),
    .negate_mode (negate_mode_r),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_result_r <= core_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = out_result_r.sample;
  assign out_sample_update = out_result_r.sample_update;
  assign out_period_now    = out_result_r.period_now;

  // APB register file: one word, always ready, no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == ADDR_NEGATE_MODE[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? {31'd0, negate_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_mode_r <= 1'b0;
    end else if (cfg_wr && cfg_hit) begin
      negate_mode_r <= cfg_pwdata[0];
    end
  end

  // A beat processed by the core always lands in the result register.
  `PCDS_ASSERT_NXT(a_step_fills_output, step_en, out_valid_r)
  // A nonzero recomputed sample means the period was at least the minimum.
  `PCDS_ASSERT_IMP(a_sample_needs_period,
    out_valid_r && out_result_r.sample_update && (out_result_r.sample != '0),
    out_result_r.period_now >= MIN_PERIOD)
  // A stalled result keeps the input register from being overwritten.
  `PCDS_ASSERT_NXT(a_stall_holds_stage,
    s1_valid_r && out_valid_r && !out_ready, s1_valid_r && $stable(s1_item_r))

endmodule
